>>> sv/bsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared constants, register codes and types of the byte unstuffing deframer.
// ----------------------------------------------------------------------------
package bsd_pkg;

  localparam int INDEX_BITS = 12;
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 3;
  localparam int POS_W      = 12;
  localparam int LEN_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  // wide enough for the length register and for a count of 2^INDEX_BITS
  localparam int CMP_W      = (LEN_W > INDEX_BITS + 1) ? LEN_W : INDEX_BITS + 1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_START    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DATA     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BADESC   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESC      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_HEAD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_TAIL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_ESC  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RESYNC   = 3'd7;

  // register reset values
  localparam logic [BYTE_W-1:0] RST_HEAD     = 8'h7E;
  localparam logic [BYTE_W-1:0] RST_TAIL     = 8'hFF;
  localparam logic [BYTE_W-1:0] RST_ESC      = 8'h8C;
  localparam logic [BYTE_W-1:0] RST_ESC_HEAD = 8'h81;
  localparam logic [BYTE_W-1:0] RST_ESC_TAIL = 8'h00;
  localparam logic [BYTE_W-1:0] RST_ESC_ESC  = 8'h73;
  localparam logic [LEN_W-1:0]  RST_MAX_LEN  = 13'd256;
  localparam logic              RST_RESYNC   = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] head;
    logic [BYTE_W-1:0] tail;
    logic [BYTE_W-1:0] esc;
    logic [BYTE_W-1:0] esc_head;
    logic [BYTE_W-1:0] esc_tail;
    logic [BYTE_W-1:0] esc_esc;
    logic [LEN_W-1:0]  max_len;
    logic              resync;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  position;
  } res_t;

endpackage

>>> sv/bsd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_if
// Valid/ready channels for raw link bytes and for deframed results.
// ----------------------------------------------------------------------------
interface bsd_in_if;
  import bsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface bsd_out_if;
  import bsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] out_byte;
  logic [POS_W-1:0]  position;

  modport source (output valid, output kind, output out_byte, output position,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input position,
                  output ready);
endinterface

>>> sv/byte_stuffing_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffing_deframer
// Recovers byte-stuffed frames between head and tail delimiters.
// ----------------------------------------------------------------------------
// Takes one raw link byte per cycle while the output is free or being taken
// and gives at most one result per byte: frame start, data byte, frame end,
// bad escape abort or overflow abort, each with the decoded byte and its
// position in the frame. A byte is held in the input register and its result
// is loaded into the result register when that is free or being taken; the
// decode of frame state, escape and length limit is combinational between.
// Escape bytes themselves and bytes other than the head seen while hunting
// give no result.
// Configuration registers may only be written while no byte is in flight.
module byte_stuffing_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  bsd_in_if.sink                         in_chan,
  bsd_out_if.source                      out_chan
);
  import bsd_pkg::*;

  cfg_t cfg;
  res_t res;
  logic out_can;

  bsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bsd_unstuff u_unstuff (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_chan (in_chan),
    .out_can (out_can),
    .res     (res)
  );

  bsd_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .out_can  (out_can),
    .out_chan (out_chan)
  );

endmodule

>>> sv/bsd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_cfg_regs
// Configuration register file: delimiters, escape codes, length limit.
// ----------------------------------------------------------------------------
module bsd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bsd_pkg::cfg_t                  cfg
);
  import bsd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HEAD:     cfg_nxt.head     = cfg_wdata[BYTE_W-1:0];
        REG_TAIL:     cfg_nxt.tail     = cfg_wdata[BYTE_W-1:0];
        REG_ESC:      cfg_nxt.esc      = cfg_wdata[BYTE_W-1:0];
        REG_ESC_HEAD: cfg_nxt.esc_head = cfg_wdata[BYTE_W-1:0];
        REG_ESC_TAIL: cfg_nxt.esc_tail = cfg_wdata[BYTE_W-1:0];
        REG_ESC_ESC:  cfg_nxt.esc_esc  = cfg_wdata[BYTE_W-1:0];
        REG_MAX_LEN:  cfg_nxt.max_len  = cfg_wdata[LEN_W-1:0];
        REG_RESYNC:   cfg_nxt.resync   = cfg_wdata[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head     <= RST_HEAD;
      cfg_r.tail     <= RST_TAIL;
      cfg_r.esc      <= RST_ESC;
      cfg_r.esc_head <= RST_ESC_HEAD;
      cfg_r.esc_tail <= RST_ESC_TAIL;
      cfg_r.esc_esc  <= RST_ESC_ESC;
      cfg_r.max_len  <= RST_MAX_LEN;
      cfg_r.resync   <= RST_RESYNC;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/bsd_unstuff.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_unstuff
// Input register, frame state and combinational unstuffing decode.
// ----------------------------------------------------------------------------
module bsd_unstuff (
  input  logic          clk,
  input  logic          rst_n,
  input  bsd_pkg::cfg_t cfg,
  bsd_in_if.sink        in_chan,
  input  logic          out_can,
  output bsd_pkg::res_t res
);
  import bsd_pkg::*;

  localparam logic [1:0] MODE_HUNT  = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_ESC   = 2'd2;

  logic                  s1_v_r;
  logic [BYTE_W-1:0]     s1_byte_r;
  logic [1:0]            mode_r;
  logic [1:0]            mode_nxt;
  logic [INDEX_BITS-1:0] idx_r;
  logic [INDEX_BITS-1:0] idx_nxt;

  logic                  adv;
  logic                  hunting;
  logic                  hit;
  logic [KIND_W-1:0]     kind;
  logic [BYTE_W-1:0]     data;
  logic [INDEX_BITS-1:0] pos;
  logic                  do_store;
  logic [CMP_W-1:0]      cap;
  logic [CMP_W-1:0]      lim;
  logic [CMP_W-1:0]      cnt;

  assign in_chan.ready = !s1_v_r || out_can;
  assign adv           = s1_v_r && out_can;
  assign hunting       = (mode_r != MODE_FRAME) && (mode_r != MODE_ESC);

  assign cap = CMP_W'(1) << INDEX_BITS;
  assign lim = (CMP_W'(cfg.max_len) > cap) ? cap : CMP_W'(cfg.max_len);

  always_comb begin
    hit      = 1'b0;
    do_store = 1'b0;
    kind     = KIND_DATA;
    data     = s1_byte_r;
    pos      = idx_r;
    mode_nxt = mode_r;
    idx_nxt  = idx_r;
    cnt      = CMP_W'(pos) + CMP_W'(1);

    priority if (s1_byte_r == cfg.head && (hunting || cfg.resync)) begin
      do_store = 1'b1;
      kind     = KIND_START;
      pos      = '0;
    end else if (hunting) begin
      mode_nxt = MODE_HUNT;
    end else if (mode_r == MODE_FRAME) begin
      priority if (s1_byte_r == cfg.esc) begin
        mode_nxt = MODE_ESC;
      end else if (s1_byte_r == cfg.tail) begin
        hit      = 1'b1;
        kind     = KIND_END;
        mode_nxt = MODE_HUNT;
        idx_nxt  = '0;
      end else begin
        do_store = 1'b1;
      end
    end else begin
      priority if (s1_byte_r == cfg.esc_head) begin
        do_store = 1'b1;
        data     = cfg.head;
      end else if (s1_byte_r == cfg.esc_tail) begin
        do_store = 1'b1;
        data     = cfg.tail;
      end else if (s1_byte_r == cfg.esc_esc) begin
        do_store = 1'b1;
        data     = cfg.esc;
      end else begin
        hit      = 1'b1;
        kind     = KIND_BADESC;
        data     = '0;
        mode_nxt = MODE_HUNT;
        idx_nxt  = '0;
      end
    end

    if (do_store) begin
      hit = 1'b1;
      cnt = CMP_W'(pos) + CMP_W'(1);
      // the stored count reaching the limit drops the frame
      if (cnt >= lim) begin
        kind     = KIND_OVERFLOW;
        mode_nxt = MODE_HUNT;
        idx_nxt  = '0;
      end else begin
        mode_nxt = MODE_FRAME;
        idx_nxt  = cnt[INDEX_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      mode_r <= MODE_HUNT;
      idx_r  <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        mode_r <= mode_nxt;
        idx_r  <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.in_byte;
    end
  end

  assign res.valid    = adv && hit;
  assign res.kind     = kind;
  assign res.data     = data;
  assign res.position = POS_W'(pos);

endmodule

>>> sv/bsd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module bsd_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  bsd_pkg::res_t res,
  output logic          out_can,
  bsd_out_if.source     out_chan
);
  import bsd_pkg::*;

  logic              out_v_r;
  logic [KIND_W-1:0] kind_r;
  logic [BYTE_W-1:0] byte_r;
  logic [POS_W-1:0]  pos_r;

  // free, or emptied by a transfer in this cycle
  assign out_can = !out_v_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_can) begin
      out_v_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_can && res.valid) begin
      kind_r <= res.kind;
      byte_r <= res.data;
      pos_r  <= res.position;
    end
  end

  assign out_chan.valid    = out_v_r;
  assign out_chan.kind     = kind_r;
  assign out_chan.out_byte = byte_r;
  assign out_chan.position = pos_r;

endmodule

>>> sv/bsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_checker
// Port-level checks on the deframer output, bound to the top level.
// ----------------------------------------------------------------------------
module bsd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bsd_pkg::KIND_W-1:0] out_kind,
  input logic [bsd_pkg::POS_W-1:0]  out_position
);
  import bsd_pkg::*;

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_START |-> out_position == '0)
    else $error("frame start not at position zero");

  // everything after the head sits at a later position; a head can overflow
  a_later_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_START && out_kind != KIND_OVERFLOW
      |-> out_position != '0)
    else $error("non-start result at position zero");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= KIND_OVERFLOW)
    else $error("undefined result kind");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind byte_stuffing_deframer bsd_checker u_bsd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_kind     (out_chan.kind),
  .out_position (out_chan.position)
);

>>> tb/byte_stuffing_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffing_deframer_test
// Self-checking bench for the byte unstuffing deframer.
// ----------------------------------------------------------------------------
// Raw link bytes go in over the input channel. Each accepted byte runs
// through a behavioural deframer kept in step with the block, and any result
// it gives is queued. Every result transfer is checked field by field against
// the oldest queued one. A short scripted sequence covers escapes, resync,
// bad escapes and frame end. Random frames follow under several register
// settings: extreme delimiters, equal delimiters, zero and full length limits.
// Both sides idle at random and the receiver stalls for a long stretch once.
module byte_stuffing_deframer_test;
  import bsd_pkg::*;

  typedef enum logic [1:0] {
    MODE_HUNT      = 2'd0,
    MODE_IN_FRAME  = 2'd1,
    MODE_AFTER_ESC = 2'd2
  } frame_mode_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  position;
  } deframe_result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] link_byte;
    bit                fixed;      // expectation written into the row
    bit                yields;
    deframe_result_t   res;
  } script_row_t;

  localparam int unsigned INDEX_SPAN = 1 << INDEX_BITS;
  localparam deframe_result_t NO_RESULT = '0;
  localparam int HOLD_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bsd_in_if  in_ch ();
  bsd_out_if out_ch ();

  byte_stuffing_deframer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // behavioural deframer state and its copy of the registers
  cfg_t        model_cfg = '{head: RST_HEAD, tail: RST_TAIL, esc: RST_ESC,
                             esc_head: RST_ESC_HEAD, esc_tail: RST_ESC_TAIL,
                             esc_esc: RST_ESC_ESC, max_len: RST_MAX_LEN,
                             resync: RST_RESYNC};
  frame_mode_e frame_mode = MODE_HUNT;
  int unsigned stored_count = 0;

  deframe_result_t results_q[$];
  int results_predicted = 0;
  int mismatches = 0;

  int tx_idle_pct = 13;
  int rx_idle_pct = 86;
  bit hold_trig = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  function automatic bit store_byte(input logic [KIND_W-1:0] kind,
                                    input logic [BYTE_W-1:0] value,
                                    output deframe_result_t r);
    int unsigned limit;
    limit = (32'(model_cfg.max_len) > INDEX_SPAN) ? INDEX_SPAN
                                                 : 32'(model_cfg.max_len);
    r.data = value;
    r.position = stored_count[POS_W-1:0];
    stored_count = stored_count + 1;
    if (stored_count >= limit) begin
      r.kind = KIND_OVERFLOW;
      frame_mode = MODE_HUNT;
      stored_count = 0;
    end else begin
      r.kind = kind;
    end
    return 1'b1;
  endfunction

  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b,
                                      output deframe_result_t r);
    bit hunting;
    logic [BYTE_W-1:0] value;
    r = NO_RESULT;
    hunting = (frame_mode == MODE_HUNT);
    if (b == model_cfg.head && (hunting || model_cfg.resync)) begin
      frame_mode = MODE_IN_FRAME;
      stored_count = 0;
      return store_byte(KIND_START, b, r);
    end
    if (hunting)
      return 1'b0;
    if (frame_mode == MODE_IN_FRAME) begin
      if (b == model_cfg.esc) begin
        frame_mode = MODE_AFTER_ESC;
        return 1'b0;
      end
      if (b == model_cfg.tail) begin
        r = '{KIND_END, b, stored_count[POS_W-1:0]};
        frame_mode = MODE_HUNT;
        stored_count = 0;
        return 1'b1;
      end
      return store_byte(KIND_DATA, b, r);
    end
    // second byte of an escape pair
    if (b == model_cfg.esc_head)
      value = model_cfg.head;
    else if (b == model_cfg.esc_tail)
      value = model_cfg.tail;
    else if (b == model_cfg.esc_esc)
      value = model_cfg.esc;
    else begin
      r = '{KIND_BADESC, 8'h00, stored_count[POS_W-1:0]};
      frame_mode = MODE_HUNT;
      stored_count = 0;
      return 1'b1;
    end
    frame_mode = MODE_IN_FRAME;
    return store_byte(KIND_DATA, value, r);
  endfunction

  // offer one byte, wait for its transfer, queue what it should give
  task automatic transfer_byte(input logic [BYTE_W-1:0] b, input bit fixed,
                               input bit fixed_yields,
                               input deframe_result_t fixed_res);
    deframe_result_t r;
    bit yields;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    yields = deframe_byte(b, r);
    if (fixed) begin
      yields = fixed_yields;
      r = fixed_res;
    end
    if (yields) begin
      results_q.push_back(r);
      results_predicted++;
    end
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    transfer_byte(b, 1'b0, 1'b0, NO_RESULT);
  endtask

  // called at a falling edge right after a transfer
  task automatic wait_until_quiet();
    in_ch.valid <= 1'b0;
    while (results_q.size() != 0)
      @(negedge clk);
    // bytes that give no result may still be in the pipeline
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    wait_until_quiet();
    put_reg(REG_HEAD, CFG_DATA_W'(c.head));
    put_reg(REG_TAIL, CFG_DATA_W'(c.tail));
    put_reg(REG_ESC, CFG_DATA_W'(c.esc));
    put_reg(REG_ESC_HEAD, CFG_DATA_W'(c.esc_head));
    put_reg(REG_ESC_TAIL, CFG_DATA_W'(c.esc_tail));
    put_reg(REG_ESC_ESC, CFG_DATA_W'(c.esc_esc));
    put_reg(REG_MAX_LEN, CFG_DATA_W'(c.max_len));
    put_reg(REG_RESYNC, CFG_DATA_W'(c.resync));
    cfg_wr_en <= 1'b0;
    model_cfg = c;
  endtask

  // clean frames stuff every delimiter value; others may break off
  task automatic send_frame(input int len, input bit clean);
    logic [BYTE_W-1:0] v;
    int pick;
    send_byte(model_cfg.head);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      v = BYTE_W'($urandom_range(255));
      if (pick < 5)
        v = model_cfg.head;
      else if (pick < 10)
        v = model_cfg.tail;
      else if (pick < 15)
        v = model_cfg.esc;
      if (!clean && pick >= 94) begin
        send_byte(v);
      end else if (!clean && pick >= 90) begin
        send_byte(model_cfg.esc);
        send_byte(BYTE_W'($urandom_range(255)));
      end else if (v == model_cfg.head || v == model_cfg.tail || v == model_cfg.esc) begin
        send_byte(model_cfg.esc);
        if (v == model_cfg.head)
          send_byte(model_cfg.esc_head);
        else if (v == model_cfg.tail)
          send_byte(model_cfg.esc_tail);
        else
          send_byte(model_cfg.esc_esc);
      end else begin
        send_byte(v);
      end
    end
    if (clean || $urandom_range(3) != 0)
      send_byte(model_cfg.tail);
  endtask

  task automatic run_frames(input int n_results);
    int stop_at;
    int len;
    stop_at = results_predicted + n_results;
    while (results_predicted < stop_at) begin
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(255)));
      len = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(12);
      send_frame(len, $urandom_range(99) < 75);
    end
  endtask

  task automatic run_random_config(input int n_results);
    cfg_t c;
    c.head     = BYTE_W'($urandom_range(255));
    c.tail     = BYTE_W'($urandom_range(255));
    c.esc      = BYTE_W'($urandom_range(255));
    c.esc_head = BYTE_W'($urandom_range(255));
    c.esc_tail = BYTE_W'($urandom_range(255));
    c.esc_esc  = BYTE_W'($urandom_range(255));
    c.max_len  = LEN_W'($urandom_range(1, 64));
    c.resync   = 1'($urandom_range(1));
    write_config(c);
    run_frames(n_results);
  endtask

  // receiver: random ready, plus one long hold-off on request
  always begin
    if (hold_seen != hold_trig) begin
      hold_seen = hold_trig;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
    @(negedge clk);
  end

  always @(posedge clk) begin : check_results
    deframe_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_q.size() == 0) begin
        $display("%0t ns: mismatch: unexpected result kind %0d byte %h position %0d",
                 $time, out_ch.kind, out_ch.out_byte, out_ch.position);
        mismatches++;
      end else begin
        want = results_q.pop_front();
        if (out_ch.kind !== want.kind) begin
          $display("%0t ns: mismatch on kind: expected %0d, got %0d",
                   $time, want.kind, out_ch.kind);
          mismatches++;
        end
        if (out_ch.out_byte !== want.data) begin
          $display("%0t ns: mismatch on out_byte: expected %h, got %h",
                   $time, want.data, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.position !== want.position) begin
          $display("%0t ns: mismatch on position: expected %0d, got %0d",
                   $time, want.position, out_ch.position);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    script_row_t directed_rows [24];
    cfg_t c;

    // reset register values throughout
    directed_rows = '{
      '{8'h00, 1'b1, 1'b0, NO_RESULT},                             // ignored while hunting
      '{8'hFF, 1'b1, 1'b0, NO_RESULT},
      '{8'h8C, 1'b1, 1'b0, NO_RESULT},
      '{8'h7E, 1'b1, 1'b1, '{KIND_START, 8'h7E, 12'd0}},
      '{8'h00, 1'b1, 1'b1, '{KIND_DATA, 8'h00, 12'd1}},
      '{8'h8C, 1'b1, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},                             // escaped tail
      '{8'h8C, 1'b1, 1'b0, NO_RESULT},
      '{8'h81, 1'b0, 1'b0, NO_RESULT},                             // escaped head
      '{8'h8C, 1'b1, 1'b0, NO_RESULT},
      '{8'h73, 1'b0, 1'b0, NO_RESULT},                             // escaped escape
      '{8'h8C, 1'b1, 1'b0, NO_RESULT},
      '{8'h8C, 1'b1, 1'b1, '{KIND_BADESC, 8'h00, 12'd5}},
      '{8'h55, 1'b1, 1'b0, NO_RESULT},
      '{8'h7E, 1'b1, 1'b1, '{KIND_START, 8'h7E, 12'd0}},
      '{8'hA5, 1'b0, 1'b0, NO_RESULT},
      '{8'h7E, 1'b1, 1'b1, '{KIND_START, 8'h7E, 12'd0}},           // restart inside frame
      '{8'h8C, 1'b1, 1'b0, NO_RESULT},
      '{8'h7E, 1'b1, 1'b1, '{KIND_START, 8'h7E, 12'd0}},           // restart after escape
      '{8'h5A, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 1'b1, '{KIND_END, 8'hFF, 12'd2}},
      '{8'h7E, 1'b1, 1'b1, '{KIND_START, 8'h7E, 12'd0}},
      '{8'h8C, 1'b1, 1'b0, NO_RESULT},
      '{8'h01, 1'b1, 1'b1, '{KIND_BADESC, 8'h00, 12'd1}}
    };

    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_HEAD;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sender mostly busy, receiver mostly stalled
    tx_idle_pct = 13;
    rx_idle_pct = 86;
    foreach (directed_rows[i])
      transfer_byte(directed_rows[i].link_byte, directed_rows[i].fixed,
                    directed_rows[i].yields, directed_rows[i].res);
    run_frames(80);

    c = '{head: 8'h00, tail: 8'hFF, esc: 8'h01, esc_head: 8'hFE, esc_tail: 8'h80,
          esc_esc: 8'h7F, max_len: 13'd16, resync: 1'b0};
    write_config(c);
    run_frames(40);
    // long receiver stall while frames keep coming, so the input backs up
    hold_trig = ~hold_trig;
    run_frames(30);
    run_frames(40);

    // sender mostly idle, receiver mostly ready
    tx_idle_pct = 86;
    rx_idle_pct = 13;
    // all delimiters equal: head wins while hunting, escape inside a frame
    c = '{head: 8'h55, tail: 8'h55, esc: 8'h55, esc_head: 8'hAA, esc_tail: 8'hAA,
          esc_esc: 8'hAA, max_len: 13'd3, resync: 1'b0};
    write_config(c);
    run_frames(80);

    c = '{head: 8'hFF, tail: 8'h00, esc: 8'h80, esc_head: 8'h00, esc_tail: 8'hFF,
          esc_esc: 8'h01, max_len: 13'h1FFF, resync: 1'b1};
    write_config(c);
    run_frames(50);
    wait_until_quiet();
    run_frames(50);

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    c = '{head: RST_HEAD, tail: RST_TAIL, esc: RST_ESC, esc_head: RST_ESC_HEAD,
          esc_tail: RST_ESC_TAIL, esc_esc: RST_ESC_ESC, max_len: 13'd4096,
          resync: 1'b1};
    write_config(c);
    run_frames(50);

    c.max_len = 13'd0;
    write_config(c);
    run_frames(12);

    c.max_len = 13'd1;
    write_config(c);
    run_frames(12);

    run_random_config(80);
    run_random_config(80);

    wait_until_quiet();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
